### src/crc16d_pkg.sv
// Package for the CRC-16 packet deframer: frame layout constants, status and
// result kind codes, and the result word type. No dependencies.
package crc16d_pkg;

    localparam int PAYLOAD_BYTES = 17;
    localparam int HDR_BYTES = 11;
    localparam int PACKET_BYTES = HDR_BYTES + PAYLOAD_BYTES + 4;

    localparam int POS_W = 7;
    localparam int IDX_W = 6;
    localparam int STATUS_W = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_PAYLOAD_FIRST = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] POS_PAYLOAD_END = POS_W'(HDR_BYTES + PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    localparam logic [CFG_INDEX_W-1:0] REG_START_CODE_MIN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_CODE_MAX = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_END = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_START = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERROR = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_LENGTH_ERROR = 3'd4;

    typedef struct packed {
        logic                result_kind;
        logic [7:0]          payload_byte;
        logic [IDX_W-1:0]    payload_index;
        logic [7:0]          start_code;
        logic [31:0]         sequence_id;
        logic [7:0]          message_id_a;
        logic [7:0]          message_id_b;
        logic [31:0]         timestamp;
        logic [STATUS_W-1:0] status;
        logic                packet_ok;
    } result_word_t;

endpackage

### src/crc16d_ifs.sv
// Handshake channels of the CRC-16 packet deframer: the received byte channel
// and the result channel. Depends on crc16d_pkg for field widths.
interface crc16d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc16d_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 result_kind;
    logic [7:0]                           payload_byte;
    logic [crc16d_pkg::IDX_W-1:0]         payload_index;
    logic [7:0]                           start_code;
    logic [31:0]                          sequence_id;
    logic [7:0]                           message_id_a;
    logic [7:0]                           message_id_b;
    logic [31:0]                          timestamp;
    logic [crc16d_pkg::STATUS_W-1:0]      status;
    logic                                 packet_ok;

    modport source (
        output valid, output result_kind, output payload_byte, output payload_index,
        output start_code, output sequence_id, output message_id_a,
        output message_id_b, output timestamp, output status, output packet_ok,
        input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input payload_index,
        input start_code, input sequence_id, input message_id_a,
        input message_id_b, input timestamp, input status, input packet_ok,
        output ready
    );
endinterface

### src/crc16d_crc_byte.sv
// Byte-wide CRC-16-CCITT update, MSB first, unrolled over the eight bits.
// Depends on crc16d_pkg for the polynomial.
module crc16d_crc_byte (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import crc16d_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

### src/crc16d_out_buffer.sv
// Two-entry result buffer: an output register and a skid register, so the
// byte side stays ready while one result waits. Depends on crc16d_pkg, crc16d_ifs.
module crc16d_out_buffer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  crc16d_pkg::result_word_t push_word,
    output logic                     space,
    crc16d_result_if.source          result
);
    import crc16d_pkg::*;

    logic         out_valid_reg;
    result_word_t out_word_reg;
    logic         skid_valid_reg;
    result_word_t skid_word_reg;
    logic         out_free;

    assign space = !skid_valid_reg;
    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : push_word;
        end
        else if (push)
        begin
            skid_word_reg <= push_word;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.result_kind   = out_word_reg.result_kind;
    assign result.payload_byte  = out_word_reg.payload_byte;
    assign result.payload_index = out_word_reg.payload_index;
    assign result.start_code    = out_word_reg.start_code;
    assign result.sequence_id   = out_word_reg.sequence_id;
    assign result.message_id_a  = out_word_reg.message_id_a;
    assign result.message_id_b  = out_word_reg.message_id_b;
    assign result.timestamp     = out_word_reg.timestamp;
    assign result.status        = out_word_reg.status;
    assign result.packet_ok     = out_word_reg.packet_ok;

endmodule

### src/crc16_packet_deframer.sv
// CRC-16 packet deframer top level: header capture, payload forwarding,
// CRC and framing checks. Depends on crc16d_pkg, crc16d_ifs and both submodules.
//
// The block takes one packet byte per clock cycle while the result buffer has
// space, and registers the result a byte causes in the buffer's output register
// (or its skid register while that waits). The byte-wide CRC update and status
// checks are combinational from the packet state registers to those. A two-entry
// result buffer keeps the byte side ready while one result waits on the result
// side; the byte side stalls only when both entries are full.
module crc16_packet_deframer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [crc16d_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [crc16d_pkg::CFG_DATA_W-1:0]     cfg_data,
    crc16d_byte_if.sink                           pkt,
    crc16d_result_if.source                       result
);
    import crc16d_pkg::*;

    logic [7:0]       start_code_min_reg;
    logic [7:0]       start_code_max_reg;

    logic [POS_W-1:0] position_reg;
    logic [15:0]      crc_reg;
    logic [7:0]       held_old_reg;
    logic [7:0]       held_new_reg;
    logic [7:0]       start_reg;
    logic [31:0]      sequence_reg;
    logic [7:0]       ident_a_reg;
    logic [7:0]       ident_b_reg;
    logic [31:0]      time_reg;

    logic [7:0]       start_next;
    logic [31:0]      sequence_next;
    logic [7:0]       ident_a_next;
    logic [7:0]       ident_b_next;
    logic [31:0]      time_next;
    logic [15:0]      crc_fed;
    logic [15:0]      crc_next;

    logic             space;
    logic             accept;
    logic             push;
    logic             in_payload;
    logic [POS_W-1:0] payload_offset;
    logic [STATUS_W-1:0] status;
    result_word_t     word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_min_reg <= 8'h00;
            start_code_max_reg <= 8'hFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_CODE_MIN: start_code_min_reg <= cfg_data;
                REG_START_CODE_MAX: start_code_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pkt.ready = space;
    assign accept = pkt.valid && space;

    crc16d_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data    (held_old_reg),
        .crc_out (crc_fed)
    );

    assign crc_next = (position_reg >= POS_W'(2)) ? crc_fed : crc_reg;

    always_comb
    begin
        start_next    = start_reg;
        sequence_next = sequence_reg;
        ident_a_next  = ident_a_reg;
        ident_b_next  = ident_b_reg;
        time_next     = time_reg;
        if (position_reg == POS_W'(0))
        begin
            start_next = pkt.data_byte;
        end
        else if (position_reg <= POS_W'(4))
        begin
            sequence_next = {sequence_reg[23:0], pkt.data_byte};
        end
        else if (position_reg == POS_W'(5))
        begin
            ident_a_next = pkt.data_byte;
        end
        else if (position_reg == POS_W'(6))
        begin
            ident_b_next = pkt.data_byte;
        end
        else if (position_reg <= POS_W'(10))
        begin
            time_next = {time_reg[23:0], pkt.data_byte};
        end
    end

    always_comb
    begin
        if (held_new_reg != BYTE_CR || pkt.data_byte != BYTE_LF)
        begin
            status = STATUS_BAD_END;
        end
        else if (start_next < start_code_min_reg || start_next > start_code_max_reg)
        begin
            status = STATUS_BAD_START;
        end
        else if (crc_next != 16'h0000)
        begin
            status = STATUS_CRC_ERROR;
        end
        else if (position_reg != POS_LAST)
        begin
            status = STATUS_LENGTH_ERROR;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    assign in_payload = (position_reg >= POS_PAYLOAD_FIRST) &&
                        (position_reg < POS_PAYLOAD_END);
    assign payload_offset = position_reg - POS_PAYLOAD_FIRST;

    always_comb
    begin
        word = '0;
        if (pkt.last_byte)
        begin
            word.result_kind  = KIND_SUMMARY;
            word.start_code   = start_next;
            word.sequence_id  = sequence_next;
            word.message_id_a = ident_a_next;
            word.message_id_b = ident_b_next;
            word.timestamp    = time_next;
            word.status       = status;
            word.packet_ok    = (status == STATUS_OK);
        end
        else
        begin
            word.result_kind   = KIND_PAYLOAD;
            word.payload_byte  = pkt.data_byte;
            word.payload_index = payload_offset[IDX_W-1:0];
        end
    end

    assign push = accept && (pkt.last_byte || in_payload);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            crc_reg      <= CRC_INIT;
            held_old_reg <= 8'h00;
            held_new_reg <= 8'h00;
            start_reg    <= 8'h00;
            sequence_reg <= 32'h0;
            ident_a_reg  <= 8'h00;
            ident_b_reg  <= 8'h00;
            time_reg     <= 32'h0;
        end
        else if (accept)
        begin
            if (pkt.last_byte)
            begin
                position_reg <= '0;
                crc_reg      <= CRC_INIT;
                held_old_reg <= 8'h00;
                held_new_reg <= 8'h00;
                start_reg    <= 8'h00;
                sequence_reg <= 32'h0;
                ident_a_reg  <= 8'h00;
                ident_b_reg  <= 8'h00;
                time_reg     <= 32'h0;
            end
            else
            begin
                if (position_reg != POS_SAT)
                begin
                    position_reg <= position_reg + POS_W'(1);
                end
                crc_reg      <= crc_next;
                held_old_reg <= held_new_reg;
                held_new_reg <= pkt.data_byte;
                start_reg    <= start_next;
                sequence_reg <= sequence_next;
                ident_a_reg  <= ident_a_next;
                ident_b_reg  <= ident_b_next;
                time_reg     <= time_next;
            end
        end
    end

    crc16d_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (word),
        .space     (space),
        .result    (result)
    );

endmodule
